// ----- rtl/hlva_pkg.sv -----
// Shared types, codes and the sine recipe for the Hough line vote accumulator.
package hlva_pkg;

  // Operation codes of a request
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_VOTE  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAGNITUDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD_ANGLES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RHO_SCALE     = 3'd4;

  // Field widths
  localparam int CFG_DATA_W = 24;
  localparam int DIM_W      = 13;
  localparam int PIX_W      = 12;
  localparam int MAG_W      = 16;
  localparam int SCALE_W    = 24;
  localparam int IDX_W      = 8;
  localparam int BIN_W      = 32;

  // Datapath widths
  localparam int XW      = PIX_W + 2;        // pixel minus center, signed
  localparam int TRIG_W  = 16;               // signed Q1.14
  localparam int MUL_W   = XW + TRIG_W;
  localparam int RHO_W   = MUL_W + 2;
  localparam int PROD_W  = RHO_W + SCALE_W + 1;
  localparam int VW      = PROD_W + 1;
  localparam int FRAC_W  = 30;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned TAYLOR_DIV [1:5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

  typedef struct packed {
    logic load;       // capture the accepted request
    logic vote_step;  // issue the current angle into the pipeline
    logic clr_step;   // zero one bin and advance
    logic rd_issue;   // read the captured bin
    logic out_load;   // move read data into the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic vote_en;    // magnitude meets the threshold
    logic t_last;     // last angle index
    logic clr_last;   // last bin of the sweep
    logic pipe_busy;  // votes still in flight
  } ctl_sts_t;

  // Sine of a 32-bit turn phase as signed Q1.14, Taylor series in Q30.
  function automatic logic signed [TRIG_W-1:0] sin_q14(input logic [31:0] phase);
    logic [1:0]        quad;
    longint unsigned   r;
    longint unsigned   x;
    longint unsigned   term;
    longint            sum;
    longint            m;
    quad = phase[31:30];
    r    = 64'(phase[29:0]);
    if (quad[0]) begin
      r = 64'h4000_0000 - r;
    end
    x    = (r * PI_Q30) >> 31;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 5; n++) begin
      term = ((((term * x) >> 30) * x) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    m = (sum + 64'sd32768) >>> 16;
    if (quad[1]) begin
      m = -m;
    end
    return TRIG_W'(m);
  endfunction

endpackage

// ----- rtl/hlva_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hlva_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/hlva_ctrl.sv -----
// Controller state machine: request sequencing, clear sweep and output handshake.
module hlva_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  output logic               out_valid,
  input  logic               out_ready,
  input  hlva_pkg::ctl_sts_t sts,
  output hlva_pkg::ctl_cmd_t cmd
);
  import hlva_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VOTE,
    ST_DRAIN,
    ST_READ,
    ST_RD_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cmd.load      = accept;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_VOTE:  state_nxt = sts.vote_en ? ST_VOTE : ST_IDLE;
            OP_READ:  state_nxt = ST_READ;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_VOTE: begin
        cmd.vote_step = 1'b1;
        if (sts.t_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last read-modify-write to land
        if (!sts.pipe_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/hlva_datapath.sv -----
// Datapath: configuration, trig table, rho pipeline, bin store and read-out.
module hlva_datapath #(
  parameter int NTHETA     = 256,
  parameter int NRHO       = 256,
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [hlva_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hlva_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [hlva_pkg::PIX_W-1:0]          in_pixel_x,
  input  logic [hlva_pkg::PIX_W-1:0]          in_pixel_y,
  input  logic [hlva_pkg::MAG_W-1:0]          in_magnitude,
  input  logic [hlva_pkg::IDX_W-1:0]          in_bin_angle,
  input  logic [hlva_pkg::IDX_W-1:0]          in_bin_distance,
  output logic [hlva_pkg::BIN_W-1:0]          out_bin_value,
  input  hlva_pkg::ctl_cmd_t                  cmd,
  output hlva_pkg::ctl_sts_t                  sts
);
  import hlva_pkg::*;

  localparam int DEPTH = NRHO * NTHETA;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(NTHETA);
  localparam int KW    = $clog2(2 * NTHETA);
  localparam int DW    = $clog2(NRHO);
  localparam int PXW   = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'd1 << PXW) - 64'd1);

  // configuration
  logic [DIM_W-1:0]   width_r, height_r;
  logic [MAG_W-1:0]   min_mag_r;
  logic               fold_r;
  logic [SCALE_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= DIM_W'(256);
      height_r  <= DIM_W'(256);
      min_mag_r <= '0;
      fold_r    <= 1'b0;
      scale_r   <= SCALE_W'(46341);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:   width_r   <= cfg_wdata[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  height_r  <= cfg_wdata[DIM_W-1:0];
        CFG_MIN_MAGNITUDE: min_mag_r <= cfg_wdata[MAG_W-1:0];
        CFG_FOLD_ANGLES:   fold_r    <= cfg_wdata[0];
        CFG_RHO_SCALE:     scale_r   <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  logic signed [XW-1:0] x_r, y_r;
  logic [MAG_W-1:0]     mag_r;
  logic [AW-1:0]        rd_addr_r;
  logic                 rd_hit_r;
  logic [PIX_W-1:0]     px_m, py_m;

  assign px_m = in_pixel_x & PIX_MASK;
  assign py_m = in_pixel_y & PIX_MASK;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r       <= $signed({2'b00, px_m}) - $signed({2'b00, width_r[DIM_W-1:1]});
      y_r       <= $signed({2'b00, py_m}) - $signed({2'b00, height_r[DIM_W-1:1]});
      mag_r     <= in_magnitude;
      rd_addr_r <= AW'(32'(in_bin_distance) * 32'(NTHETA) + 32'(in_bin_angle));
      rd_hit_r  <= (32'(in_bin_angle) < 32'(NTHETA)) && (32'(in_bin_distance) < 32'(NRHO));
    end
  end

  // sine / cosine table, one pair per half-turn step of pi/NTHETA
  logic signed [TRIG_W-1:0] sin_rom [2*NTHETA];
  logic signed [TRIG_W-1:0] cos_rom [2*NTHETA];

  for (genvar k = 0; k < 2 * NTHETA; k++) begin : g_rom
    localparam logic [31:0] PH =
      32'(((64'(k) << 32) + 64'(NTHETA)) / 64'(2 * NTHETA));
    assign sin_rom[k] = sin_q14(PH);
    assign cos_rom[k] = sin_q14(PH + 32'h4000_0000);
  end

  // angle and clear counters
  logic [TW-1:0] t_r;
  logic [AW-1:0] clr_addr_r;
  logic [KW-1:0] rom_idx;

  assign sts.t_last   = (t_r == TW'(NTHETA - 1));
  assign sts.clr_last = (clr_addr_r == AW'(DEPTH - 1));
  assign sts.vote_en  = (in_magnitude >= min_mag_r);
  assign rom_idx      = fold_r ? KW'(t_r) : {t_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r        <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.vote_step) begin
        t_r <= sts.t_last ? '0 : t_r + TW'(1);
      end
      if (cmd.clr_step) begin
        clr_addr_r <= sts.clr_last ? '0 : clr_addr_r + AW'(1);
      end
    end
  end

  // vote pipeline: table, products, rho, scale, bin, read-modify-write
  logic                       v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [TW-1:0]              t1_r, t2_r, t3_r, t4_r, t5_r;
  logic signed [TRIG_W-1:0]   sin1_r, cos1_r;
  logic signed [MUL_W-1:0]    xc_r, ys_r;
  logic signed [RHO_W-1:0]    rho_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic [DW-1:0]              bin5_r;
  logic [AW-1:0]              addr6_r;
  logic signed [VW-1:0]       vsum;
  logic                       hit;
  logic [DW-1:0]              bin;
  logic [AW-1:0]              vote_addr;

  always_comb begin
    vsum = (VW'(NRHO) <<< 29) + VW'(prod_r);
    if (vsum[VW-1]) begin
      // just below zero still truncates to bin zero
      hit = (&vsum[VW-1:FRAC_W]) && (|vsum[FRAC_W-1:0]);
      bin = '0;
    end else begin
      hit = (vsum[VW-2:FRAC_W] < (VW-1-FRAC_W)'(NRHO));
      bin = vsum[FRAC_W +: DW];
    end
  end

  assign vote_addr = AW'(32'(bin5_r) * 32'(NTHETA) + 32'(t5_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= cmd.vote_step;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r && hit;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_r    <= t_r;
    sin1_r  <= sin_rom[rom_idx];
    cos1_r  <= cos_rom[rom_idx];
    t2_r    <= t1_r;
    xc_r    <= x_r * cos1_r;
    ys_r    <= y_r * sin1_r;
    t3_r    <= t2_r;
    rho_r   <= -(RHO_W'(xc_r) + RHO_W'(ys_r));
    t4_r    <= t3_r;
    prod_r  <= rho_r * $signed({1'b0, scale_r});
    t5_r    <= t4_r;
    bin5_r  <= bin;
    addr6_r <= vote_addr;
  end

  assign sts.pipe_busy = v1_r | v2_r | v3_r | v4_r | v5_r | v6_r;

  // bin store
  logic              ram_we, ram_rd_en;
  logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
  logic [BIN_W-1:0]  ram_wr_data, ram_rd_data;
  logic [BIN_W:0]    acc_sum;

  assign acc_sum     = {1'b0, ram_rd_data} + (BIN_W+1)'(mag_r);
  assign ram_we      = cmd.clr_step | v6_r;
  assign ram_wr_addr = cmd.clr_step ? clr_addr_r : addr6_r;
  assign ram_wr_data = cmd.clr_step ? '0 : (acc_sum[BIN_W] ? '1 : acc_sum[BIN_W-1:0]);
  assign ram_rd_en   = cmd.rd_issue | v5_r;
  assign ram_rd_addr = cmd.rd_issue ? rd_addr_r : vote_addr;

  hlva_ram #(
    .WIDTH(BIN_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // output register
  logic [BIN_W-1:0] out_bin_value_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_bin_value_r <= rd_hit_r ? ram_rd_data : '0;
    end
  end

  assign out_bin_value = out_bin_value_r;

endmodule

// ----- rtl/hough_line_vote_accumulator_top.sv -----
// Top level of the Hough line vote accumulator: controller plus datapath.
//
//   Port group | Direction | Handshake            | Carries
//   in_*       | input     | in_valid / in_ready  | operation, pixel, magnitude, bin to read
//   out_*      | output    | out_valid / out_ready| bin_value of a read
//   cfg_*      | input     | cfg_wr_en            | register index and write data
//
// Vote: one angle issued per cycle into a six-stage
//   read-modify-write pipeline, then ST_DRAIN waits until the pipeline has emptied.
// Clear: all NRHO*NTHETA bins, one zeroed per cycle through the single write port.
// Reset starts the same clearing pass; in_ready stays low.
// Read: ST_READ, then ST_RD_WAIT, which holds while the output register is still full.
// Votes and clears go on while a read result waits to be taken.
module hough_line_vote_accumulator_top #(
  parameter int NTHETA     = 256,
  parameter int NRHO       = 256,
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_operation,
  input  logic [hlva_pkg::PIX_W-1:0]          in_pixel_x,
  input  logic [hlva_pkg::PIX_W-1:0]          in_pixel_y,
  input  logic [hlva_pkg::MAG_W-1:0]          in_magnitude,
  input  logic [hlva_pkg::IDX_W-1:0]          in_bin_angle,
  input  logic [hlva_pkg::IDX_W-1:0]          in_bin_distance,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hlva_pkg::BIN_W-1:0]          out_bin_value,
  input  logic                                cfg_wr_en,
  input  logic [hlva_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hlva_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import hlva_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  hlva_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  hlva_datapath #(
    .NTHETA    (NTHETA),
    .NRHO      (NRHO),
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_magnitude   (in_magnitude),
    .in_bin_angle   (in_bin_angle),
    .in_bin_distance(in_bin_distance),
    .out_bin_value  (out_bin_value),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ----- bench/hough_vote_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the Hough vote accumulator: mirrors the bin store and checks each read.
module hough_vote_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [1:0]                      in_operation,
  input  logic [hlva_pkg::PIX_W-1:0]      in_pixel_x,
  input  logic [hlva_pkg::PIX_W-1:0]      in_pixel_y,
  input  logic [hlva_pkg::MAG_W-1:0]      in_magnitude,
  input  logic [hlva_pkg::IDX_W-1:0]      in_bin_angle,
  input  logic [hlva_pkg::IDX_W-1:0]      in_bin_distance,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [hlva_pkg::BIN_W-1:0]      out_bin_value,
  input  logic                            cfg_wr_en,
  input  logic [hlva_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hlva_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              reads_owed,
  output int                              reads_checked
);
  import hlva_pkg::*;

  localparam int ANGLES = 256;
  localparam int DISTS  = 256;
  localparam int ROM_N  = 2 * ANGLES;
  localparam longint unsigned PI_IN_Q30 = 64'd3373259426;

  bit   [31:0] tally [ANGLES*DISTS];
  longint      cos_tab [ROM_N];
  longint      sin_tab [ROM_N];
  logic [12:0] width_q;
  logic [12:0] height_q;
  logic [15:0] floor_q;
  logic        fold_q;
  logic [23:0] scale_q;
  logic [31:0] owed_bins [$];

  // Sine over a quarter turn in Q30; offs is the quarter-turn fraction in 2^30 units.
  function automatic longint quarter_sine_q30(input longint unsigned offs);
    longint unsigned ang;
    longint unsigned term;
    longint          acc;
    ang  = (offs * PI_IN_Q30) >> 31;
    term = ang;
    acc  = longint'(ang);
    for (int n = 1; n <= 5; n++) begin
      term = ((((term * ang) >> 30) * ang) >> 30) / longint'(2 * n * (2 * n + 1));
      if (n % 2 == 1) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    return (acc < 0) ? 64'sd0 : acc;
  endfunction

  // Sine of a full 32-bit turn phase, signed Q1.14.
  function automatic longint turn_sine_q14(input logic [31:0] phase);
    longint unsigned offs;
    longint          mag;
    offs = 64'(phase[29:0]);
    if (phase[30]) begin
      offs = 64'h4000_0000 - offs;
    end
    mag = (quarter_sine_q30(offs) + 64'sd32768) >>> 16;
    return phase[31] ? -mag : mag;
  endfunction

  initial begin
    logic [31:0] ph;
    for (int k = 0; k < ROM_N; k++) begin
      ph = 32'(((64'(k) << 32) + 64'(ANGLES)) / 64'(ROM_N));
      sin_tab[k] = turn_sine_q14(ph);
      cos_tab[k] = turn_sine_q14(ph + 32'h4000_0000);
    end
  end

  // Walk every angle and add the weight to the distance bin it lands in.
  task automatic spread_vote(input logic [11:0] px, input logic [11:0] py,
                             input logic [15:0] mag);
    longint      dx;
    longint      dy;
    longint      rho;
    longint      pos_q30;
    int          k;
    int          dist_bin;
    int          idx;
    logic [32:0] total;
    dx = longint'(px) - longint'(width_q >> 1);
    dy = longint'(py) - longint'(height_q >> 1);
    for (int t = 0; t < ANGLES; t++) begin
      k       = fold_q ? t : 2 * t;
      rho     = -(dx * cos_tab[k] + dy * sin_tab[k]);
      pos_q30 = longint'(DISTS) * (64'sd1 <<< 29) + rho * longint'(scale_q);
      // truncate toward zero: anything above -1.0 still lands in bin 0
      if (pos_q30 < 0) begin
        dist_bin = (((-pos_q30) >>> 30) != 0) ? -1 : 0;
      end else begin
        dist_bin = ((pos_q30 >>> 30) >= DISTS) ? -1 : int'(pos_q30 >>> 30);
      end
      if (dist_bin >= 0) begin
        idx        = dist_bin * ANGLES + t;
        total      = 33'(tally[idx]) + 33'(mag);
        tally[idx] = total[32] ? 32'hFFFF_FFFF : total[31:0];
      end
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_q  = 13'd256;
      height_q = 13'd256;
      floor_q  = '0;
      fold_q   = 1'b0;
      scale_q  = 24'd46341;
      foreach (tally[i]) tally[i] = '0;
      owed_bins.delete();
      reads_owed = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:   width_q  = cfg_wdata[12:0];
          CFG_IMAGE_HEIGHT:  height_q = cfg_wdata[12:0];
          CFG_MIN_MAGNITUDE: floor_q  = cfg_wdata[15:0];
          CFG_FOLD_ANGLES:   fold_q   = cfg_wdata[0];
          CFG_RHO_SCALE:     scale_q  = cfg_wdata[23:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (owed_bins.size() == 0) begin
          note_failure($sformatf("bin_value %h arrived with no read pending", out_bin_value));
        end else begin
          if (owed_bins[0] !== out_bin_value) begin
            note_failure($sformatf("bin_value mismatch: expected %h, got %h",
                                   owed_bins[0], out_bin_value));
          end
          void'(owed_bins.pop_front());
          reads_checked++;
        end
      end
      if (in_valid && in_ready) begin
        case (in_operation)
          OP_CLEAR: foreach (tally[i]) tally[i] = '0;
          OP_VOTE: begin
            if (in_magnitude >= floor_q) begin
              spread_vote(in_pixel_x, in_pixel_y, in_magnitude);
            end
          end
          OP_READ: owed_bins.push_back(tally[{in_bin_distance, in_bin_angle}]);
          default: ;
        endcase
      end
      reads_owed = owed_bins.size();
    end
  end

endmodule

// ----- bench/tb_hough_line_vote_accumulator_top.sv -----
`timescale 1ns / 100ps
// Testbench top: stimulus, register settings and verdict for the Hough vote accumulator.
module tb_hough_line_vote_accumulator_top;
  import hlva_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 2500;
  localparam int PHASE_ITEMS  = 290;

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic [1:0]            in_operation    = OP_CLEAR;
  logic [PIX_W-1:0]      in_pixel_x      = '0;
  logic [PIX_W-1:0]      in_pixel_y      = '0;
  logic [MAG_W-1:0]      in_magnitude    = '0;
  logic [IDX_W-1:0]      in_bin_angle    = '0;
  logic [IDX_W-1:0]      in_bin_distance = '0;
  logic                  out_ready       = 1'b0;
  logic                  cfg_wr_en       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata       = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic [BIN_W-1:0]      out_bin_value;

  int   fail_count;
  int   reads_owed;
  int   reads_checked;
  logic calm        = 1'b0;
  int   hold_asked  = 0;
  int   hold_served = 0;
  int   hold_left   = 0;
  int   sent_votes  = 0;
  int   sent_reads  = 0;
  int   sent_clears = 0;
  int   sent_unused = 0;
  int   settings    = 0;
  int   cur_w       = 256;
  int   cur_h       = 256;
  int   cur_min     = 0;
  logic [11:0] hot_x [4];
  logic [11:0] hot_y [4];

  always #5 clk = ~clk;

  hough_line_vote_accumulator_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_magnitude    (in_magnitude),
    .in_bin_angle    (in_bin_angle),
    .in_bin_distance (in_bin_distance),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bin_value   (out_bin_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  hough_vote_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_magnitude    (in_magnitude),
    .in_bin_angle    (in_bin_angle),
    .in_bin_distance (in_bin_distance),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bin_value   (out_bin_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .reads_owed      (reads_owed),
    .reads_checked   (reads_checked)
  );

  // Result side: random stalls, plus a long hold-off whenever one is asked for.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 24);
    end
  end

  initial begin
    #60_000_000;
    $display("simulation failed");
    $finish;
  end

  // Offer one request and hold it until taken; valid stays high on return.
  task automatic send_request(input logic [1:0] op, input logic [11:0] px,
                              input logic [11:0] py, input logic [15:0] mag,
                              input logic [7:0] ang, input logic [7:0] dist_idx);
    if (!calm) begin
      while ($urandom_range(99) < 24) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_pixel_x      <= px;
    in_pixel_y      <= py;
    in_magnitude    <= mag;
    in_bin_angle    <= ang;
    in_bin_distance <= dist_idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (op)
      OP_CLEAR: sent_clears++;
      OP_VOTE:  sent_votes++;
      OP_READ:  sent_reads++;
      default:  sent_unused++;
    endcase
    @(negedge clk);
  endtask

  task automatic vote_at(input logic [11:0] px, input logic [11:0] py,
                         input logic [15:0] mag);
    send_request(OP_VOTE, px, py, mag, 8'($urandom), 8'($urandom));
  endtask

  task automatic read_at(input logic [7:0] ang, input logic [7:0] dist_idx);
    send_request(OP_READ, 12'($urandom), 12'($urandom), 16'($urandom), ang, dist_idx);
  endtask

  task automatic clear_all();
    send_request(OP_CLEAR, 12'($urandom), 12'($urandom), 16'($urandom),
                 8'($urandom), 8'($urandom));
  endtask

  // Drop valid and wait for every read owed so far.
  task automatic drain_reads();
    in_valid <= 1'b0;
    @(negedge clk);
    while (reads_owed != 0 || !in_ready) @(negedge clk);
  endtask

  // A final read orders behind all earlier work; then let the vote pipeline empty.
  task automatic settle();
    read_at(8'd0, 8'd128);
    drain_reads();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(negedge clk);
  endtask

  task automatic set_registers(input int w, input int h, input int mn, input int fold,
                               input int scale);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_MIN_MAGNITUDE, mn);
    write_reg(CFG_FOLD_ANGLES, fold);
    write_reg(CFG_RHO_SCALE, scale);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    cur_w   = w;
    cur_h   = h;
    cur_min = mn;
    settings++;
  endtask

  function automatic logic [11:0] in_image(input int span);
    int lim;
    lim = (span <= 0) ? 1 : ((span > 4096) ? 4096 : span);
    return 12'($urandom_range(lim - 1));
  endfunction

  task automatic random_request();
    int          pick;
    int          sel;
    int          m;
    logic [11:0] px;
    logic [11:0] py;
    logic [15:0] mag;
    logic [7:0]  dist_idx;
    pick = $urandom_range(99);
    sel  = $urandom_range(9);
    if (sel < 3) begin
      // hammer a few pixels so their bins build up large totals
      px = hot_x[sel];
      py = hot_y[sel];
    end else if (sel < 8) begin
      px = in_image(cur_w);
      py = in_image(cur_h);
    end else begin
      px = 12'($urandom);
      py = 12'($urandom);
    end
    if ($urandom_range(3) == 0) begin
      m = cur_min + int'($urandom_range(4)) - 2;
      m = (m < 0) ? 0 : ((m > 65535) ? 65535 : m);
      mag = 16'(m);
    end else begin
      mag = 16'($urandom);
    end
    dist_idx = ($urandom_range(9) < 6) ? 8'(80 + $urandom_range(96)) : 8'($urandom);
    if (pick < 3) begin
      send_request(OP_UNUSED, px, py, mag, 8'($urandom), dist_idx);
    end else if (pick < 58) begin
      vote_at(px, py, mag);
    end else begin
      read_at(8'($urandom), dist_idx);
    end
  endtask

  task automatic run_phase(input int w, input int h, input int mn, input int fold,
                           input int scale, input bit clear_first);
    set_registers(w, h, mn, fold, scale);
    for (int i = 0; i < 4; i++) begin
      hot_x[i] = in_image(cur_w);
      hot_y[i] = in_image(cur_h);
    end
    if (clear_first) begin
      clear_all();
    end
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 4) begin
        drain_reads();
      end
      if (i == PHASE_ITEMS / 2) begin
        hold_asked <= hold_asked + 1;
      end
      if (i == (2 * PHASE_ITEMS) / 3) begin
        calm <= 1'b1;
      end
      if (i == (2 * PHASE_ITEMS) / 3 + 60) begin
        calm <= 1'b0;
      end
      random_request();
    end
    settle();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: centered 256x256 image, full turn
    read_at(8'd0, 8'd0);
    vote_at(12'd128, 12'd128, 16'hFFFF);
    read_at(8'd0, 8'd128);
    read_at(8'd255, 8'd128);
    read_at(8'd170, 8'd128);
    vote_at(12'd0, 12'd0, 16'h0000);
    vote_at(12'hFFF, 12'hFFF, 16'hFFFF);
    vote_at(12'hFFF, 12'd0, 16'h8000);
    vote_at(12'd0, 12'hFFF, 16'h0001);
    send_request(OP_UNUSED, 12'hFFF, 12'hFFF, 16'hFFFF, 8'hFF, 8'hFF);
    read_at(8'd255, 8'd255);
    read_at(8'd0, 8'd0);
    read_at(8'd64, 8'd200);
    clear_all();
    read_at(8'd0, 8'd128);
    vote_at(12'd128, 12'd128, 16'h1234);
    read_at(8'd99, 8'd128);
    settle();

    run_phase(256, 256, 0, 1, 46341, 1'b0);
    run_phase(4096, 4096, 1000, 0, 2896, 1'b1);
    // zero size and zero scale: every vote lands in the middle distance bin
    run_phase(0, 0, 0, 0, 0, 1'b0);
    run_phase(8191, 1, 65535, 1, 24'hFF_FFFF, 1'b1);
    run_phase(1, 8191, 1, 0, 65536, 1'b0);
    run_phase(100, 60, 300, 1, 200000, 1'b0);

    $display("covered %0d votes, %0d reads, %0d clears, %0d unused codes", sent_votes,
             sent_reads, sent_clears, sent_unused);
    $display("over %0d register settings; %0d read results compared", settings,
             reads_checked);
    if (fail_count == 0 && reads_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hlva_pkg.sv
rtl/hlva_ram.sv
rtl/hlva_ctrl.sv
rtl/hlva_datapath.sv
rtl/hough_line_vote_accumulator_top.sv
bench/hough_vote_checker.sv
bench/tb_hough_line_vote_accumulator_top.sv
